/* sv/wgl_pkg.sv */
// Shared types, widths and codes of the window grid layout block.
`default_nettype none

package wgl_pkg;

    // Largest window count that is laid out; larger counts saturate to it
    localparam int MAX_WINDOWS = 64;

    // Field widths of the words on either stream
    localparam int CNT_W   = 7;
    localparam int IDX_W   = 6;
    localparam int COORD_W = 16;
    localparam int AREA_W  = 15;
    localparam int MODE_W  = 2;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 72;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Column count is at most floor(sqrt(MAX_WINDOWS)), plus one while searching
    localparam int COLS_W = 4;
    localparam int SQ_W   = 2 * COLS_W;

    // Serial divider: area size or count over a column or row count
    localparam int DIV_NW = AREA_W;
    localparam int DIV_DW = CNT_W;
    localparam int DIV_CW = 4;

    // Saturation limit at the width of the count field
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_WINDOWS);

    // Layout mode codes; any other code lays tiles out vertically
    localparam logic [MODE_W-1:0] MODE_CASCADE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TILE_H  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TILE_V  = 2'd2;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_X = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_Y = 3'd6;

    // Destination of a divider result
    typedef enum logic [1:0] {
        DIV_PER = 2'd0,
        DIV_COL = 2'd1,
        DIV_ROW = 2'd2
    } t_div_sel;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic     load;
        logic     casc_init;
        logic     sqrt_step;
        logic     div_start;
        t_div_sel div_sel;
        logic     col_start;
        logic     emit;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic cnt_zero;
        logic casc;
        logic sqrt_done;
        logic div_done;
        logic out_free;
        logic last;
        logic col_end;
    } t_stat;

endpackage

`default_nettype wire

/* sv/wgl_div.sv */
// Restoring serial divider, one quotient bit per cycle.
`default_nettype none

module wgl_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [wgl_pkg::DIV_NW-1:0] i_dividend,
    input  wire logic [wgl_pkg::DIV_DW-1:0] i_divisor,
    output logic                           o_busy,
    output logic                           o_done,
    output logic [wgl_pkg::DIV_NW-1:0]     o_quot,
    output logic [wgl_pkg::DIV_DW-1:0]     o_rem
);

    localparam logic [wgl_pkg::DIV_CW-1:0] LAST_STEP = wgl_pkg::DIV_CW'(wgl_pkg::DIV_NW - 1);

    logic                          r_busy;
    logic                          r_done;
    logic [wgl_pkg::DIV_CW-1:0]    r_step;
    logic [wgl_pkg::DIV_NW-1:0]    r_quo;
    logic [wgl_pkg::DIV_DW-1:0]    r_rem;
    logic [wgl_pkg::DIV_DW-1:0]    r_den;

    logic [wgl_pkg::DIV_DW:0]      w_trial;
    logic [wgl_pkg::DIV_DW:0]      w_diff;
    logic                          w_ge;

    // Shift in the next dividend bit and try to subtract
    assign w_trial = {r_rem, r_quo[wgl_pkg::DIV_NW-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});
    assign w_diff  = w_trial - {1'b0, r_den};

    // Control: busy over the bit steps, done for one cycle after the last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: partial remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[wgl_pkg::DIV_NW-2:0], w_ge};
            r_rem <= w_ge ? w_diff[wgl_pkg::DIV_DW-1:0] : w_trial[wgl_pkg::DIV_DW-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

/* sv/wgl_dp.sv */
// Datapath: configuration registers, column search, divisions, offsets, output word.
`default_nettype none

module wgl_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [wgl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [wgl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [wgl_pkg::CNT_W-1:0]      i_count,
    input  wire wgl_pkg::t_cmd                  i_cmd,
    output wgl_pkg::t_stat                     o_stat,
    input  wire logic                          i_m_tready,
    output logic                               o_m_tvalid,
    output logic [wgl_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    output logic                               o_m_tlast
);

    // Configuration registers
    logic [wgl_pkg::MODE_W-1:0]  r_mode;
    logic [wgl_pkg::COORD_W-1:0] r_left;
    logic [wgl_pkg::COORD_W-1:0] r_top;
    logic [wgl_pkg::AREA_W-1:0]  r_width;
    logic [wgl_pkg::AREA_W-1:0]  r_height;
    logic [wgl_pkg::COORD_W-1:0] r_step_x;
    logic [wgl_pkg::COORD_W-1:0] r_step_y;

    // Layout control
    logic [wgl_pkg::CNT_W-1:0]   r_cnt;
    logic [wgl_pkg::COLS_W-1:0]  r_cols;
    logic [wgl_pkg::CNT_W-1:0]   r_per;
    logic [wgl_pkg::COLS_W-1:0]  r_rem;
    logic [wgl_pkg::COLS_W-1:0]  r_col_idx;
    logic [wgl_pkg::CNT_W-1:0]   r_row_idx;
    logic [wgl_pkg::CNT_W-1:0]   r_z;
    logic [wgl_pkg::CNT_W-1:0]   r_idx;
    wgl_pkg::t_div_sel           r_div_sel;

    // Steps and offsets
    logic [wgl_pkg::COORD_W-1:0] r_cstep;
    logic [wgl_pkg::COORD_W-1:0] r_rstep;
    logic [wgl_pkg::COORD_W-1:0] r_coff;
    logic [wgl_pkg::COORD_W-1:0] r_roff;

    // Output register
    logic                        r_ov;
    logic [wgl_pkg::IDX_W-1:0]   r_o_idx;
    logic [wgl_pkg::COORD_W-1:0] r_o_left;
    logic [wgl_pkg::COORD_W-1:0] r_o_top;
    logic [wgl_pkg::COORD_W-1:0] r_o_width;
    logic [wgl_pkg::COORD_W-1:0] r_o_height;
    logic                        r_o_last;

    logic                        w_casc;
    logic                        w_horiz;
    logic                        w_vert;
    logic [wgl_pkg::CNT_W-1:0]   w_count_sat;
    logic [wgl_pkg::COLS_W-1:0]  w_cols_nxt;
    logic [wgl_pkg::SQ_W-1:0]    w_cols_sq_nxt;
    logic [wgl_pkg::SQ_W-1:0]    w_cols_sq;
    logic [wgl_pkg::COLS_W-1:0]  w_thresh;
    logic [wgl_pkg::CNT_W-1:0]   w_z_next;
    logic [wgl_pkg::CNT_W+wgl_pkg::COORD_W-1:0] w_prod_x;
    logic [wgl_pkg::CNT_W+wgl_pkg::COORD_W-1:0] w_prod_y;
    logic [wgl_pkg::DIV_NW-1:0]  w_div_num;
    logic [wgl_pkg::DIV_DW-1:0]  w_div_den;
    logic                        w_div_busy;
    logic                        w_div_done;
    logic [wgl_pkg::DIV_NW-1:0]  w_div_quot;
    logic [wgl_pkg::DIV_DW-1:0]  w_div_rem;
    logic                        w_out_free;
    logic                        w_last;
    logic                        w_col_end;

    assign w_casc  = (r_mode == wgl_pkg::MODE_CASCADE);
    assign w_horiz = (r_mode == wgl_pkg::MODE_TILE_H);
    assign w_vert  = !w_casc && !w_horiz;

    assign w_count_sat = (i_count > wgl_pkg::CNT_MAX) ? wgl_pkg::CNT_MAX : i_count;

    // Column search: grow while the next square still fits the count
    assign w_cols_nxt    = r_cols + 1'b1;
    assign w_cols_sq_nxt = w_cols_nxt * w_cols_nxt;
    assign w_cols_sq     = r_cols * r_cols;

    // Window count of the column about to start
    assign w_thresh = r_cols - r_rem;
    assign w_z_next = (r_col_idx < w_thresh) ? r_per : r_per + 1'b1;

    // Cascade size products, low 16 bits kept
    assign w_prod_x = r_cnt * r_step_x;
    assign w_prod_y = r_cnt * r_step_y;

    assign w_out_free = !r_ov || i_m_tready;
    assign w_last     = (r_idx + 1'b1 == r_cnt);
    assign w_col_end  = (r_row_idx + 1'b1 == r_z);

    // Select divider operands for the requested quotient
    always_comb begin
        case (i_cmd.div_sel)
            wgl_pkg::DIV_PER: begin
                w_div_num = wgl_pkg::DIV_NW'(r_cnt);
                w_div_den = wgl_pkg::DIV_DW'(r_cols);
            end
            wgl_pkg::DIV_COL: begin
                w_div_num = w_horiz ? r_width : r_height;
                w_div_den = wgl_pkg::DIV_DW'(r_cols);
            end
            wgl_pkg::DIV_ROW: begin
                w_div_num = w_horiz ? r_height : r_width;
                w_div_den = w_z_next;
            end
            default: begin
                w_div_num = '0;
                w_div_den = '0;
            end
        endcase
    end

    wgl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_div_num),
        .i_divisor  (w_div_den),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot),
        .o_rem      (w_div_rem)
    );

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= wgl_pkg::MODE_CASCADE;
            r_left   <= 16'd0;
            r_top    <= 16'd0;
            r_width  <= 15'd640;
            r_height <= 15'd480;
            r_step_x <= 16'd16;
            r_step_y <= 16'd16;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                wgl_pkg::REG_MODE:   r_mode   <= i_cfg_data[wgl_pkg::MODE_W-1:0];
                wgl_pkg::REG_LEFT:   r_left   <= i_cfg_data;
                wgl_pkg::REG_TOP:    r_top    <= i_cfg_data;
                wgl_pkg::REG_WIDTH:  r_width  <= i_cfg_data[wgl_pkg::AREA_W-1:0];
                wgl_pkg::REG_HEIGHT: r_height <= i_cfg_data[wgl_pkg::AREA_W-1:0];
                wgl_pkg::REG_STEP_X: r_step_x <= i_cfg_data;
                wgl_pkg::REG_STEP_Y: r_step_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Counters and indexes of the run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_cols    <= '0;
            r_col_idx <= '0;
            r_row_idx <= '0;
            r_idx     <= '0;
            r_z       <= '0;
            r_div_sel <= wgl_pkg::DIV_PER;
        end else begin
            if (i_cmd.load) begin
                r_cnt     <= w_count_sat;
                r_cols    <= '0;
                r_col_idx <= '0;
                r_row_idx <= '0;
                r_idx     <= '0;
            end
            if (i_cmd.casc_init) begin
                r_z <= r_cnt;
            end
            if (i_cmd.sqrt_step && (w_cols_sq_nxt <= wgl_pkg::SQ_W'(r_cnt))) begin
                r_cols <= w_cols_nxt;
            end
            if (i_cmd.div_start) begin
                r_div_sel <= i_cmd.div_sel;
            end
            if (i_cmd.col_start) begin
                r_z       <= w_z_next;
                r_row_idx <= '0;
            end
            if (i_cmd.emit) begin
                r_idx     <= r_idx + 1'b1;
                r_row_idx <= r_row_idx + 1'b1;
                if (!w_casc && w_col_end) begin
                    r_col_idx <= r_col_idx + 1'b1;
                end
            end
        end
    end

    // Steps from divider results or cascade sizes; advance offsets per word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_coff <= '0;
            r_roff <= '0;
        end
        if (i_cmd.casc_init) begin
            r_cstep <= {1'b0, r_width} - w_prod_x[wgl_pkg::COORD_W-1:0];
            r_rstep <= {1'b0, r_height} - w_prod_y[wgl_pkg::COORD_W-1:0];
        end
        if (w_div_done) begin
            case (r_div_sel)
                wgl_pkg::DIV_PER: begin
                    r_per <= w_div_quot[wgl_pkg::CNT_W-1:0];
                    r_rem <= w_div_rem[wgl_pkg::COLS_W-1:0];
                end
                wgl_pkg::DIV_COL: r_cstep <= {1'b0, w_div_quot};
                wgl_pkg::DIV_ROW: r_rstep <= {1'b0, w_div_quot};
                default: ;
            endcase
        end
        if (i_cmd.col_start) begin
            r_roff <= '0;
        end
        if (i_cmd.emit) begin
            if (w_casc) begin
                r_coff <= r_coff + r_step_x;
                r_roff <= r_roff + r_step_y;
            end else begin
                r_roff <= r_roff + r_rstep;
                if (w_col_end) begin
                    r_coff <= r_coff + r_cstep;
                end
            end
        end
    end

    // Output word valid: set on emit, clear when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ov <= 1'b1;
        end else if (i_m_tready) begin
            r_ov <= 1'b0;
        end
    end

    // Output word payload; vertical tiling swaps the roles of the axes
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_idx    <= r_idx[wgl_pkg::IDX_W-1:0];
            r_o_left   <= r_left + (w_vert ? r_roff : r_coff);
            r_o_top    <= r_top + (w_vert ? r_coff : r_roff);
            r_o_width  <= w_vert ? r_rstep : r_cstep;
            r_o_height <= w_vert ? r_cstep : r_rstep;
            r_o_last   <= w_last;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tlast  = r_o_last;
    assign o_m_tdata  = {2'b00, r_o_height, r_o_width, r_o_top, r_o_left, r_o_idx};

    always_comb begin
        o_stat.cnt_zero  = (r_cnt == '0);
        o_stat.casc      = w_casc;
        o_stat.sqrt_done = (w_cols_sq_nxt > wgl_pkg::SQ_W'(r_cnt));
        o_stat.div_done  = w_div_done;
        o_stat.out_free  = w_out_free;
        o_stat.last      = w_last;
        o_stat.col_end   = w_col_end;
    end

`ifndef SYNTHESIS
    // An emit never overwrites a word that has not been taken
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_ov || i_m_tready))
        else $error("emit into a full output register");

    // The divider is started only when it is idle
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |-> !w_div_busy)
        else $error("divider restarted while busy");

    // The column count never exceeds the square root of the count
    a_cols_fit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cols_sq <= wgl_pkg::SQ_W'(r_cnt))
        else $error("column count too large");

    // No word past the end of the run
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (r_idx < r_cnt))
        else $error("window index beyond count");
`endif

endmodule

`default_nettype wire

/* sv/wgl_ctrl.sv */
// Controller state machine: sequences load, column search, divisions and emission.
`default_nettype none

module wgl_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire wgl_pkg::t_stat i_stat,
    output wgl_pkg::t_cmd       o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE      = 10'b0000000001,
        S_LOAD      = 10'b0000000010,
        S_SQRT      = 10'b0000000100,
        S_DIV_PER   = 10'b0000001000,
        S_WAIT_PER  = 10'b0000010000,
        S_DIV_COL   = 10'b0000100000,
        S_WAIT_COL  = 10'b0001000000,
        S_COL_START = 10'b0010000000,
        S_WAIT_ROW  = 10'b0100000000,
        S_EMIT      = 10'b1000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_LOAD;
                end
            end
            S_LOAD: begin
                if (i_stat.cnt_zero) begin
                    n_state = S_IDLE;
                end else if (i_stat.casc) begin
                    o_cmd.casc_init = 1'b1;
                    n_state         = S_EMIT;
                end else begin
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (i_stat.sqrt_done) begin
                    n_state = S_DIV_PER;
                end
            end
            S_DIV_PER: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = wgl_pkg::DIV_PER;
                n_state         = S_WAIT_PER;
            end
            S_WAIT_PER: begin
                if (i_stat.div_done) begin
                    n_state = S_DIV_COL;
                end
            end
            S_DIV_COL: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = wgl_pkg::DIV_COL;
                n_state         = S_WAIT_COL;
            end
            S_WAIT_COL: begin
                if (i_stat.div_done) begin
                    n_state = S_COL_START;
                end
            end
            S_COL_START: begin
                o_cmd.col_start = 1'b1;
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = wgl_pkg::DIV_ROW;
                n_state         = S_WAIT_ROW;
            end
            S_WAIT_ROW: begin
                if (i_stat.div_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.last) begin
                        n_state = S_IDLE;
                    end else if (!i_stat.casc && i_stat.col_end) begin
                        n_state = S_COL_START;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* sv/window_grid_layout_top.sv */
// Window grid layout: count in, one rectangle word per window out.
//
// Input stream (s_axis): one word carries a window count. Output stream
// (m_axis): one word per window in list order, tlast on the final one. A
// count of zero produces no output; counts above 64 are laid out as 64.
// Configuration: write i_cfg_data to register i_cfg_idx while i_cfg_we is
// high (mode, area left/top/width/height, cascade steps x/y); write only
// while the block is idle.
// Cascade runs go from loading straight to output, one word per cycle
// while the receiver takes them. Tile runs do the column search and two
// shared divisions, then a division per column of z windows before its
// words; the 15-step divider sets the per-column cost. One request at
// a time is taken; s_axis_tready is high whenever no run is in progress.
// Results pass through a one-word output register: the next request can be
// taken while the final word still waits. A stalled receiver holds the
// run at its current word with nothing lost.
// Reset (synchronous, active low) restores the register defaults and drops
// any run in progress and any pending output word.
`default_nettype none

module window_grid_layout_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [wgl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [wgl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // [6:0] window_count, [7] zero
    input  wire logic [wgl_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // [5:0] window_index, [21:6] rect_left, [37:22] rect_top,
    // [53:38] rect_width, [69:54] rect_height, [71:70] zero
    output logic [wgl_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                               m_axis_tlast
);

    wgl_pkg::t_cmd  w_cmd;
    wgl_pkg::t_stat w_stat;

    wgl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    wgl_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_count    (s_axis_tdata[wgl_pkg::CNT_W-1:0]),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_m_tready (m_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

/* sim/tb_window_grid_layout_top.sv */
// Self-checking testbench of the window grid layout block: directed and random layout runs.
`timescale 1ns / 1ps

module tb_window_grid_layout_top;
    import wgl_pkg::*;

    // Cycles to let the block wind down before a register write or the end
    localparam int SETTLE_CYCLES = 300;
    // Cycles with no accepted word before the run is called hung
    localparam int STALL_LIMIT   = 4000;
    // Mode code outside the defined set
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    // One rectangle as it travels on the output stream
    typedef struct packed {
        logic [IDX_W-1:0]   index;
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] width;
        logic [COORD_W-1:0] height;
        logic               last;
    } t_rect;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;
    logic                   s_axis_tvalid = 1'b0;
    wire                    s_axis_tready;
    // [6:0] window_count, [7] zero
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    wire                    m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [5:0] window_index, [21:6] rect_left, [37:22] rect_top,
    // [53:38] rect_width, [69:54] rect_height, [71:70] zero
    wire [OUT_TDATA_W-1:0]  m_axis_tdata;
    wire                    m_axis_tlast;

    // Shadow copy of the layout registers
    logic [MODE_W-1:0]  cfg_mode     = MODE_CASCADE;
    logic [COORD_W-1:0] cfg_left     = '0;
    logic [COORD_W-1:0] cfg_top      = '0;
    logic [AREA_W-1:0]  cfg_width    = AREA_W'(640);
    logic [AREA_W-1:0]  cfg_height   = AREA_W'(480);
    logic [COORD_W-1:0] cfg_step_x   = COORD_W'(16);
    logic [COORD_W-1:0] cfg_step_y   = COORD_W'(16);

    logic [CNT_W-1:0] count_queue[$];
    t_rect            rect_expected[$];
    t_rect            word_got;
    t_rect            word_want;
    int               mismatches = 0;
    int               src_gap    = 0;
    int               sink_gap   = 0;
    int               quiet_cycles = 0;
    bit               idle_on    = 1'b1;

    window_grid_layout_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Lay out one request with the current registers and queue its rectangles
    function automatic void lay_out(input logic [CNT_W-1:0] req);
        int count, cols, per, rem, z, n, i, j;
        logic [COORD_W-1:0] w, h, l, t;
        bit horiz;
        count = (req > MAX_WINDOWS) ? MAX_WINDOWS : int'(req);
        if (count == 0)
            return;
        if (cfg_mode == MODE_CASCADE) begin
            w = {1'b0, cfg_width} - COORD_W'(count * cfg_step_x);
            h = {1'b0, cfg_height} - COORD_W'(count * cfg_step_y);
            for (n = 0; n < count; n++) begin
                l = cfg_left + COORD_W'(n * cfg_step_x);
                t = cfg_top + COORD_W'(n * cfg_step_y);
                rect_expected.push_back(t_rect'{IDX_W'(n), l, t, w, h, n == count - 1});
            end
        end else begin
            // Any mode other than cascade or horizontal tiles lays out vertically
            horiz = (cfg_mode == MODE_TILE_H);
            cols = 0;
            while ((cols + 1) * (cols + 1) <= count)
                cols++;
            per = count / cols;
            rem = count - cols * per;
            w = '0;
            h = '0;
            if (horiz)
                w = COORD_W'(int'(cfg_width) / cols);
            else
                h = COORD_W'(int'(cfg_height) / cols);
            n = 0;
            for (i = 0; i < cols; i++) begin
                z = (i < cols - rem) ? per : per + 1;
                if (horiz)
                    h = COORD_W'(int'(cfg_height) / z);
                else
                    w = COORD_W'(int'(cfg_width) / z);
                for (j = 0; j < z; j++) begin
                    if (horiz) begin
                        t = cfg_top + COORD_W'(h * j);
                        l = cfg_left + COORD_W'(w * i);
                    end else begin
                        t = cfg_top + COORD_W'(h * i);
                        l = cfg_left + COORD_W'(w * j);
                    end
                    rect_expected.push_back(t_rect'{IDX_W'(n), l, t, w, h, n == count - 1});
                    n++;
                end
            end
        end
    endfunction

    // Report one field that differs; returns 1 on a mismatch
    function automatic int field_diff(input string name, input logic signed [15:0] want,
                                      input logic signed [15:0] got);
        if (want === got)
            return 0;
        $display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
        return 1;
    endfunction

    // Register value biased toward the extremes
    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [14:0] pick15();
        case ($urandom_range(0, 4))
            0: return 15'h0000;
            1: return 15'h7FFF;
            2: return 15'($urandom_range(1, 64));
            default: return 15'($urandom);
        endcase
    endfunction

    // Write one register and mirror it in the shadow copy
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_MODE:   cfg_mode   = data[MODE_W-1:0];
            REG_LEFT:   cfg_left   = data;
            REG_TOP:    cfg_top    = data;
            REG_WIDTH:  cfg_width  = data[AREA_W-1:0];
            REG_HEIGHT: cfg_height = data[AREA_W-1:0];
            REG_STEP_X: cfg_step_x = data;
            REG_STEP_Y: cfg_step_y = data;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [1:0] mode, input logic [15:0] left, top,
                              input logic [14:0] width, height, input logic [15:0] sx, sy);
        cfg_write(REG_MODE, {14'd0, mode});
        cfg_write(REG_LEFT, left);
        cfg_write(REG_TOP, top);
        cfg_write(REG_WIDTH, {1'b0, width});
        cfg_write(REG_HEIGHT, {1'b0, height});
        cfg_write(REG_STEP_X, sx);
        cfg_write(REG_STEP_Y, sy);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Wait until every request is taken and every rectangle has come back
    task automatic settle();
        do
            @(negedge i_clk);
        while (count_queue.size() != 0 || s_axis_tvalid || rect_expected.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Feed requests from the pending queue, with random idle bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (src_gap > 0) begin
                src_gap       <= src_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (count_queue.size() != 0) begin
                s_axis_tdata  <= {1'b0, count_queue.pop_front()};
                s_axis_tvalid <= 1'b1;
                if (idle_on && $urandom_range(0, 3) == 0)
                    src_gap <= $urandom_range(1, 16);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Predict the rectangles of each accepted request
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            lay_out(s_axis_tdata[CNT_W-1:0]);
    end

    // Check each rectangle word against the oldest expectation; stall at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                word_got.index  = m_axis_tdata[5:0];
                word_got.left   = m_axis_tdata[21:6];
                word_got.top    = m_axis_tdata[37:22];
                word_got.width  = m_axis_tdata[53:38];
                word_got.height = m_axis_tdata[69:54];
                word_got.last   = m_axis_tlast;
                if (rect_expected.size() == 0) begin
                    $display("%0t mismatch: expected no word, actual index %0d", $time,
                             word_got.index);
                    mismatches++;
                end else begin
                    word_want = rect_expected.pop_front();
                    mismatches += field_diff("window_index", 16'(word_want.index),
                                             16'(word_got.index));
                    mismatches += field_diff("rect_left", word_want.left, word_got.left);
                    mismatches += field_diff("rect_top", word_want.top, word_got.top);
                    mismatches += field_diff("rect_width", word_want.width, word_got.width);
                    mismatches += field_diff("rect_height", word_want.height,
                                             word_got.height);
                    mismatches += field_diff("is_last", 16'(word_want.last),
                                             16'(word_got.last));
                end
            end
            if (sink_gap > 0) begin
                sink_gap      <= sink_gap - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (idle_on && $urandom_range(0, 7) == 0)
                    sink_gap <= $urandom_range(1, 16);
            end
        end
    end

    // Watchdog: end the run when no word moves for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t watchdog: no word moved in %0d cycles", $time, STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    // Stimulus: directed phases, then random phases with random registers
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset registers, cascade: zero, single, full, saturating counts
        @(negedge i_clk);
        count_queue = '{7'd1, 7'd0, 7'd64, 7'd127, 7'd65, 7'd2};
        settle();

        set_config(MODE_TILE_H, 16'd0, 16'd0, 15'd640, 15'd480, 16'd16, 16'd16);
        count_queue = '{7'd1, 7'd2, 7'd3, 7'd5, 7'd8, 7'd100};
        settle();

        set_config(MODE_TILE_V, -16'sd5, 16'd9, 15'd1000, 15'd777, 16'd3, -16'sd7);
        count_queue = '{7'd7, 7'd10, 7'd64};
        settle();

        // Undefined mode code behaves as vertical tiles
        set_config(MODE_SPARE, 16'd100, 16'd200, 15'd1920, 15'd1080, 16'd0, 16'd0);
        count_queue = '{7'd12, 7'd64};
        settle();

        // Extreme registers: wrapping positions and negative cascade sizes
        set_config(MODE_CASCADE, 16'h8000, 16'h7FFF, 15'h7FFF, 15'h0000, 16'h8000, 16'h7FFF);
        count_queue = '{7'd64, 7'd3};
        settle();

        set_config(MODE_TILE_H, 16'h7FFF, 16'h8000, 15'h0000, 15'h7FFF, 16'hFFFF, 16'h0001);
        count_queue = '{7'd17, 7'd63};
        settle();

        set_config(MODE_TILE_V, 16'hFFFF, 16'h0001, 15'h7FFF, 15'h0000, 16'h7FFF, 16'h8000);
        count_queue = '{7'd50, 7'd4};
        settle();

        // Random phases; the last one runs without idling
        for (int phase = 0; phase < 4; phase++) begin
            if (phase == 3)
                idle_on = 1'b0;
            set_config(2'($urandom_range(0, 3)), pick16(), pick16(), pick15(), pick15(),
                       pick16(), pick16());
            for (int k = 0; k < 34; k++) begin
                if ($urandom_range(0, 3) == 0)
                    count_queue.push_back(7'($urandom_range(0, 127)));
                else
                    count_queue.push_back(7'($urandom_range(0, 64)));
            end
            settle();
        end

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
